[sv/sdut_pkg.sv]
// Shared types and constants for the smallest divisor search block.
`timescale 1ns / 1ps
`default_nettype none
package sdut_pkg;
	localparam int LIMIT_W = 24;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_TRIAL,
		BK_DRAIN,
		BK_DECIDE,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic vld;
		logic lst;
	} fq_ctrl_t;
endpackage
`default_nettype wire

[sv/sdut_divider.sv]
// Restoring divider, one quotient bit per cycle, ceiling quotient out.
`timescale 1ns / 1ps
`default_nettype none
module sdut_divider import sdut_pkg::*; #(
	parameter int W = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic [W-1:0]      ceil_q
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, num_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W:0]    trial;

	assign trial = {rem_q, num_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (run_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign ceil_q = quo_q + W'(rem_q != '0);
endmodule
`default_nettype wire

[sv/sdut_front.sv]
// Front end: takes items and holds them in a one-entry queue for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sdut_front import sdut_pkg::*; #(
	parameter int W = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         take,
	input  wire logic [W-1:0] item_size,
	input  wire logic         last_item,
	input  wire logic         pop,
	output fq_ctrl_t          head,
	output logic [W-1:0]      head_size
);
	logic [W-1:0] size_q;
	fq_ctrl_t     ctl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else if (take) ctl_q <= '{vld: 1'b1, lst: last_item};
		else if (pop) ctl_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (take) size_q <= item_size;
	end

	assign head      = ctl_q;
	assign head_size = size_q;
endmodule
`default_nettype wire

[sv/sdut_back.sv]
// Back end: item store, maximum tracking and the binary search sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sdut_back import sdut_pkg::*; #(
	parameter int MAX_ITEMS = 4096,
	parameter int W = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fq_ctrl_t           head,
	input  wire logic [W-1:0]       head_size,
	input  wire logic [LIMIT_W-1:0] sum_limit,
	output logic                    pop,
	output logic                    idle,
	output logic                    res_vld,
	output logic [W-1:0]            res_div
);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [W-1:0]  mem [MAX_ITEMS];
	logic [W-1:0]  rd_q;
	logic [CW-1:0] count_q, idx_q;
	logic [W-1:0]  max_q, lo_q, hi_q, mid_q;
	logic [LIMIT_W:0] sum_q;
	logic          fail_q;
	bk_state_t     st_q, st_d;
	logic          div_go, div_done;
	logic [W-1:0]  cq;
	logic [LIMIT_W:0] sum_n;

	assign pop  = head.vld && st_q == BK_IDLE;
	assign idle = st_q == BK_IDLE && !head.vld;

	always_ff @(posedge clk) begin
		if (pop && count_q < CW'(MAX_ITEMS)) mem[count_q[AW-1:0]] <= head_size;
		rd_q <= mem[idx_q[AW-1:0]];
	end

	sdut_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(rd_q), .den(mid_q),
		.done(div_done), .ceil_q(cq)
	);

	assign sum_n = sum_q + (LIMIT_W + 1)'(cq);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE:   if (pop && head.lst) st_d = BK_CHECK;
			BK_CHECK:  st_d = (lo_q < hi_q) ? BK_TRIAL : BK_DONE;
			BK_TRIAL:  st_d = (idx_q >= count_q) ? BK_DECIDE : BK_DRAIN;
			BK_DRAIN:  if (div_done) st_d = BK_TRIAL;
			BK_DECIDE: st_d = BK_CHECK;
			BK_DONE:   st_d = BK_IDLE;
			default:   st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		div_go = 1'b0;
		unique case (st_q)
			BK_TRIAL: div_go = idx_q < count_q;
			default:  div_go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_IDLE;
			count_q <= '0;
			max_q   <= '0;
			lo_q    <= W'(1);
			hi_q    <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			fail_q  <= 1'b0;
			mid_q   <= '0;
			res_vld <= 1'b0;
			res_div <= '0;
		end else begin
			st_q    <= st_d;
			res_vld <= 1'b0;
			unique case (st_q)
				BK_IDLE: if (pop) begin
					logic [W-1:0] nm;
					nm = max_q;
					if (count_q < CW'(MAX_ITEMS)) begin
						count_q <= count_q + 1'b1;
						if (head_size > max_q) nm = head_size;
					end
					max_q <= nm;
					lo_q  <= W'(1);
					hi_q  <= nm;
				end
				BK_CHECK: begin
					mid_q  <= lo_q + ((hi_q - lo_q) >> 1);
					idx_q  <= '0;
					sum_q  <= '0;
					fail_q <= 1'b0;
				end
				BK_TRIAL: if (idx_q < count_q) idx_q <= idx_q + 1'b1;
				BK_DRAIN: if (div_done && !fail_q) begin
					sum_q <= sum_n;
					if (sum_n > {1'b0, sum_limit}) fail_q <= 1'b1;
				end
				BK_DECIDE: begin
					// index back to the first item so its read is ready for the next round
					idx_q <= '0;
					if (fail_q) lo_q <= mid_q + 1'b1;
					else hi_q <= mid_q;
				end
				BK_DONE: begin
					res_vld <= 1'b1;
					res_div <= lo_q;
					count_q <= '0;
					max_q   <= '0;
					idx_q   <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/smallest_divisor_under_threshold.sv]
// Top level of the smallest divisor under threshold block.
//  channel | dir | handshake           | payload
//  item    | in  | start & !busy       | item_size, last_item
//  result  | out | strobe, one cycle   | divisor
//  config  | in  | cfg_valid&cfg_ready | cfg_data (sum_limit)
// Each item passes through a one-entry queue into the store; busy holds off the next item until it has left.
// Each search round reads all held items, one at a time, through a W-step serial
// divider; about log2(max) rounds follow a last item.
// Reset clears control state and sets sum_limit to 1. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module smallest_divisor_under_threshold import sdut_pkg::*; #(
	parameter int MAX_ITEMS = 4096,
	parameter int ITEM_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [ITEM_BITS-1:0] item_size,
	input  wire logic                 last_item,
	output logic                      strobe,
	output logic [ITEM_BITS-1:0]      divisor,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [LIMIT_W-1:0]   cfg_data
);
	logic [LIMIT_W-1:0] limit_q;
	fq_ctrl_t           head;
	logic [ITEM_BITS-1:0] head_size;
	logic               pop, idle, take;

	assign take      = start && !busy;
	assign busy      = head.vld || !idle;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_W'(1);
		else if (cfg_valid && cfg_ready) limit_q <= cfg_data;
	end

	sdut_front #(.W(ITEM_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .item_size(item_size),
		.last_item(last_item), .pop(pop), .head(head), .head_size(head_size)
	);

	sdut_back #(.MAX_ITEMS(MAX_ITEMS), .W(ITEM_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_size(head_size),
		.sum_limit(limit_q), .pop(pop), .idle(idle), .res_vld(strobe),
		.res_div(divisor)
	);

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy) else $error("busy not raised after item");
	a_res_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> divisor != '0) else $error("zero divisor");
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result while idle");
endmodule
`default_nettype wire
